// File: rtl/imi_pkg.sv
// Shared types, constants and the code point classifier for the implicit
// multiply inserter. No dependencies.
`timescale 1ns / 1ps

package imi_pkg;

  // Decoded-beat queue between the UTF-8 front end and the rewriter
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [7:0]  STAR_BYTE = 8'h2A;
  localparam logic [20:0] CP_BAD    = 21'h00FFFD;
  localparam logic [20:0] CP_BULLET = 21'h002022;

  // UTF-8 lead byte masks and codes
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;

  // What the rewriter needs to know about one code point
  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_DIGIT,          // 0-9 or '.'
    CLS_OPEN_PAREN,
    CLS_CLOSE_PAREN,
    CLS_OPEN_BRACKET,
    CLS_CLOSE_BRACKET,
    CLS_NO_STAR         // operator that suppresses a '*' after ')'
  } cp_class_t;

  // One queue entry: the bytes a single input beat releases.
  // multi: all bytes form one code point of class cls; otherwise each
  // byte is a code point of its own.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      count;
    logic            multi;
    cp_class_t       cls;
    logic            last;
  } cp_entry_t;

  function automatic cp_class_t classify(input logic [20:0] cp);
    cp_class_t c;
    unique case (cp) inside
      21'h00005B:                        c = CLS_OPEN_BRACKET;
      21'h00005D:                        c = CLS_CLOSE_BRACKET;
      21'h000028:                        c = CLS_OPEN_PAREN;
      21'h000029:                        c = CLS_CLOSE_PAREN;
      [21'h000030:21'h000039], 21'h00002E: c = CLS_DIGIT;
      21'h00002B, 21'h00002D, 21'h00002A,
      21'h00002F, 21'h00005E, CP_BULLET: c = CLS_NO_STAR;
      default:                           c = CLS_OTHER;
    endcase
    return c;
  endfunction

  // Class of a byte that stands alone: ASCII as itself, anything else U+FFFD
  function automatic cp_class_t byte_class(input logic [7:0] b);
    return classify(b[7] ? CP_BAD : {13'd0, b});
  endfunction

endpackage

// File: rtl/implicit_multiply_inserter.sv
// Top level of the implicit multiply inserter: UTF-8 front end, entry queue
// and rewriter. Depends on imi_pkg, imi_front, imi_queue and imi_back.
`timescale 1ns / 1ps

// Usage
//   Input channel: a byte beat (in_byte, in_last) is taken at a rising edge
//   with push high and full low. in_last marks the final byte of a string.
//   Output channel: while empty is low, out_byte/out_last show the oldest
//   rewritten byte; it leaves at a rising edge with pop high. Every input
//   byte comes out unchanged, with an extra '*' (0x2A) before '(' after a
//   top-level digit or '.', and after ')' when the next code point sits at
//   the same bracket depth and is not + - * / ^ ) or U+2022.
//   Path: with the rewriter idle, the first beat a taken byte releases is
//   written into the queue and then into the output register; an inserted
//   '*' goes out first, ahead of the byte. The bytes of an unfinished UTF-8
//   sequence wait until the sequence completes, breaks or the string ends.
//   Throughput: one input beat per cycle while full is low. The rewriter
//   delivers one output beat per cycle while pop keeps up, so a beat releasing
//   k bytes (k up to 5 with stars) holds it until all k are out; a 4-entry
//   queue between decoder and rewriter absorbs such bursts, and full rises only when it is filled.
//   Stall: with pop low the output register holds its beat, the rewriter
//   stops, the queue fills and full then throttles the sender.
//   Reset (rst, synchronous): queue and output empty, no buffered sequence,
//   depth 0. The same context is restored after each in_last byte.
module implicit_multiply_inserter import imi_pkg::*; #(
  parameter int DEPTH_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       out_last
);

  cp_entry_t front_entry, q_head;
  logic      front_valid, q_empty, q_pop, accept;

  assign accept = push && !full;

  imi_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .entry       (front_entry),
    .entry_valid (front_valid)
  );

  imi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (front_valid),
    .push_entry (front_entry),
    .full       (full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  imi_back #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule

// File: rtl/imi_front.sv
// UTF-8 front end: groups input bytes into code points and emits one queue
// entry per beat that releases bytes. Depends on imi_pkg.
`timescale 1ns / 1ps

module imi_front import imi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  logic [7:0] in_byte,
  input  logic      in_last,
  output cp_entry_t entry,
  output logic      entry_valid
);

  logic [7:0] seq_bytes [3];
  logic [1:0] seq_have, seq_have_next;
  logic [1:0] seq_need, seq_need_next;

  logic       is_cont;
  logic [1:0] lead_need;
  logic       complete, extend, inc_b;
  logic [2:0] count;
  logic [20:0] cp;

  assign is_cont  = (in_byte & CONT_MASK) == CONT_CODE;
  assign complete = (seq_have != 2'd0) && is_cont && (seq_have == seq_need);
  assign extend   = (seq_have != 2'd0) && is_cont && (seq_have != seq_need);

  always_comb begin
    if ((in_byte & LEAD2_MASK) == LEAD2_CODE)      lead_need = 2'd1;
    else if ((in_byte & LEAD3_MASK) == LEAD3_CODE) lead_need = 2'd2;
    else if ((in_byte & LEAD4_MASK) == LEAD4_CODE) lead_need = 2'd3;
    else                                           lead_need = 2'd0;
  end

  // Buffered bytes first, then the new byte where it is released now
  always_comb begin
    if (complete)    inc_b = 1'b1;
    else if (extend) inc_b = in_last;
    else             inc_b = (lead_need == 2'd0) || in_last;
    count = (extend && !in_last) ? 3'd0 : ({1'b0, seq_have} + {2'd0, inc_b});
  end

  assign entry.data[0] = (seq_have > 2'd0) ? seq_bytes[0] : in_byte;
  assign entry.data[1] = (seq_have > 2'd1) ? seq_bytes[1] : in_byte;
  assign entry.data[2] = (seq_have > 2'd2) ? seq_bytes[2] : in_byte;
  assign entry.data[3] = in_byte;

  // Scalar value of a completed sequence, overlong forms as given
  always_comb begin
    case (seq_need)
      2'd1:    cp = {10'd0, entry.data[0][4:0], entry.data[1][5:0]};
      2'd2:    cp = {5'd0, entry.data[0][3:0], entry.data[1][5:0], entry.data[2][5:0]};
      default: cp = {entry.data[0][2:0], entry.data[1][5:0], entry.data[2][5:0],
                     entry.data[3][5:0]};
    endcase
  end

  assign entry.count = count;
  assign entry.multi = complete;
  assign entry.cls   = classify(cp);
  assign entry.last  = in_last;
  assign entry_valid = accept && (count != 3'd0);

  always_comb begin
    seq_have_next = seq_have;
    seq_need_next = seq_need;
    if (accept) begin
      if (in_last || complete) begin
        seq_have_next = 2'd0;
        seq_need_next = 2'd0;
      end else if (extend) begin
        seq_have_next = seq_have + 2'd1;
      end else if (lead_need != 2'd0) begin
        seq_have_next = 2'd1;
        seq_need_next = lead_need;
      end else begin
        seq_have_next = 2'd0;
        seq_need_next = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_have <= 2'd0;
      seq_need <= 2'd0;
    end else begin
      seq_have <= seq_have_next;
      seq_need <= seq_need_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_last) begin
      if (extend) begin
        seq_bytes[seq_have] <= in_byte;
      end else if (!complete && lead_need != 2'd0) begin
        seq_bytes[0] <= in_byte;
      end
    end
  end

`ifndef SYNTHESIS
  a_have_within_need: assert property (@(posedge clk) disable iff (rst)
    seq_have != 2'd0 |-> seq_have <= seq_need)
    else $error("front: buffered byte count exceeds lead byte demand");

  a_idle_no_need: assert property (@(posedge clk) disable iff (rst)
    seq_have == 2'd0 |-> seq_need == 2'd0)
    else $error("front: continuation demand without a buffered lead byte");
`endif

endmodule

// File: rtl/imi_queue.sv
// Short register queue of decoded entries between front end and rewriter.
// Depends on imi_pkg.
`timescale 1ns / 1ps

module imi_queue import imi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cp_entry_t push_entry,
  output logic      full,
  input  logic      pop,
  output cp_entry_t head,
  output logic      empty
);

  cp_entry_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count, count_next;
  logic                      do_push, do_pop;

  assign full    = count == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (do_push && !do_pop)      count_next = count + 1'b1;
    else if (do_pop && !do_push) count_next = count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

endmodule

// File: rtl/imi_back.sv
// Rewriter: walks queue entries byte by byte, tracks bracket depth and the
// previous code point, inserts '*' and drives the output register.
// Depends on imi_pkg.
`timescale 1ns / 1ps

module imi_back import imi_pkg::*; #(
  parameter int DEPTH_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  cp_entry_t  head,
  input  logic       q_empty,
  output logic       q_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       out_last
);

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

  logic [DEPTH_BITS-1:0] depth_count, depth_count_next;
  logic [DEPTH_BITS-1:0] close_depth, close_depth_next;
  logic                  prev_valid, prev_valid_next;
  logic                  prev_digit, prev_digit_next;
  logic                  prev_top_level, prev_top_level_next;
  logic                  close_pending, close_pending_next;
  logic [1:0]            idx, idx_next;
  logic                  star_done, star_done_next;
  logic                  out_valid;

  logic [7:0]            slot_byte;
  logic                  start, last_slot, step, want_star, emit_byte;
  logic                  star_close, star_open;
  cp_class_t             cls;
  logic [DEPTH_BITS-1:0] lvl;

  assign slot_byte = head.data[idx];
  assign start     = !head.multi || (idx == 2'd0);
  assign cls       = head.multi ? head.cls : byte_class(slot_byte);
  assign lvl       = (cls == CLS_OPEN_BRACKET && depth_count != DEPTH_MAX) ?
                     depth_count + 1'b1 : depth_count;

  assign star_close = close_pending && (close_depth == lvl) &&
                      cls != CLS_NO_STAR && cls != CLS_CLOSE_PAREN;
  assign star_open  = (cls == CLS_OPEN_PAREN) && prev_valid && prev_digit &&
                      prev_top_level;
  assign want_star  = start && !star_done && (star_close || star_open);

  assign last_slot = {1'b0, idx} == (head.count - 3'd1);
  assign step      = !q_empty && (!out_valid || pop);
  assign emit_byte = step && !want_star;
  assign q_pop     = emit_byte && last_slot;
  assign empty     = !out_valid;

  always_comb begin
    depth_count_next    = depth_count;
    close_depth_next    = close_depth;
    prev_valid_next     = prev_valid;
    prev_digit_next     = prev_digit;
    prev_top_level_next = prev_top_level;
    close_pending_next  = close_pending;
    idx_next            = idx;
    star_done_next      = star_done;
    if (step && want_star) begin
      star_done_next = 1'b1;
    end else if (emit_byte) begin
      star_done_next = 1'b0;
      idx_next       = last_slot ? 2'd0 : idx + 2'd1;
      if (start) begin
        depth_count_next    = (cls == CLS_CLOSE_BRACKET && lvl != '0) ? lvl - 1'b1 : lvl;
        prev_valid_next     = 1'b1;
        prev_digit_next     = cls == CLS_DIGIT;
        prev_top_level_next = lvl == '0;
        close_pending_next  = cls == CLS_CLOSE_PAREN;
        close_depth_next    = lvl;
      end
      // end of string: context returns to its reset values
      if (last_slot && head.last) begin
        depth_count_next    = '0;
        close_depth_next    = '0;
        prev_valid_next     = 1'b0;
        prev_digit_next     = 1'b0;
        prev_top_level_next = 1'b0;
        close_pending_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_count    <= '0;
      close_depth    <= '0;
      prev_valid     <= 1'b0;
      prev_digit     <= 1'b0;
      prev_top_level <= 1'b0;
      close_pending  <= 1'b0;
      idx            <= 2'd0;
      star_done      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      depth_count    <= depth_count_next;
      close_depth    <= close_depth_next;
      prev_valid     <= prev_valid_next;
      prev_digit     <= prev_digit_next;
      prev_top_level <= prev_top_level_next;
      close_pending  <= close_pending_next;
      idx            <= idx_next;
      star_done      <= star_done_next;
      if (step)     out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte <= want_star ? STAR_BYTE : slot_byte;
      out_last <= emit_byte && last_slot && head.last;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_entry: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> {1'b0, idx} < head.count)
    else $error("back: slot index beyond entry length");

  a_ctx_cleared_at_end: assert property (@(posedge clk) disable iff (rst)
    (emit_byte && last_slot && head.last) |=>
      (depth_count == '0 && !close_pending && !prev_valid && idx == 2'd0))
    else $error("back: context not cleared after end of string");
`endif

endmodule
